// File: hdl/spr_pkg.sv
package spr_pkg;

  localparam int unsigned MAX_LAGS_DEF   = 4096;
  localparam int unsigned PHASE_BITS_DEF = 16;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POS_W    = 14;
  localparam int unsigned FREQ_W   = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned RATE_W   = 48;
  localparam int unsigned REF_W    = 32;
  localparam int unsigned LAG_W    = 13;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = RATE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_FREQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAG_COUNT      = 2'd2;
  localparam logic [LAG_W-1:0]     LAG_COUNT_RESET    = 13'd4096;

  localparam int unsigned FRAC_Q = 30;
  localparam int unsigned X_W    = 30;
  localparam int unsigned T_W    = 31;
  localparam logic [T_W-1:0] ONE_Q    = 31'h4000_0000;
  localparam logic [32:0]    TWO_PI_Q = 33'd6746518852;
  localparam logic [X_W-1:0] X_MAX    = 30'd843314857;

  localparam int unsigned NUM_CELLS = 6;
  localparam int unsigned SIN_DIVS [NUM_CELLS] = '{110, 72, 42, 20, 6, 0};
  localparam int unsigned COS_DIVS [NUM_CELLS] = '{132, 90, 56, 30, 12, 2};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic [POS_W-1:0]           pos;
    logic                       pass;
    logic [1:0]                 quad;
    logic                       swap;
  } spr_ctx_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [X_W-1:0] x2;
    logic [T_W-1:0] ts;
    logic [T_W-1:0] tc;
  } spr_trig_t;

endpackage

// File: hdl/spectrum_phase_rotator.sv
// Rotates selected complex spectral bins by a phase that grows with the
// frequency offset and the period number, one word per clock. The block is a
// single stall-as-one pipeline of 31 stages: nine front stages form the phase,
// fold it to one octant and square the angle, a row of six cells
// each runs one Horner step of the sine and cosine series in three stages, and
// four back stages apply the quadrant, the complex multiply, the rounding and
// the saturation. An accepted word moves through the stage registers in
// order, and the whole pipeline holds while the output is stalled;
// in_ready_o is high whenever the output register is empty or is being
// taken, so a new word enters every cycle while the output keeps moving.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i and
// should change only while no word is in flight.
module spectrum_phase_rotator #(
  parameter int unsigned MAX_LAGS   = spr_pkg::MAX_LAGS_DEF,
  parameter int unsigned PHASE_BITS = spr_pkg::PHASE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [spr_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [spr_pkg::SAMPLE_W-1:0]   sample_re_i,
  input  logic signed [spr_pkg::SAMPLE_W-1:0]   sample_im_i,
  input  logic [spr_pkg::POS_W-1:0]             bin_position_i,
  input  logic signed [spr_pkg::FREQ_W-1:0]     channel_freq_i,
  input  logic [spr_pkg::PERIOD_W-1:0]          period_index_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [spr_pkg::SAMPLE_W-1:0]   out_re_o,
  output logic signed [spr_pkg::SAMPLE_W-1:0]   out_im_o,
  output logic [spr_pkg::POS_W-1:0]             out_position_o
);
  import spr_pkg::*;

  logic signed [RATE_W-1:0] rate_q;
  logic signed [REF_W-1:0]  ref_q;
  logic [LAG_W-1:0]         lag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
      ref_q  <= '0;
      lag_q  <= LAG_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROTATION_RATE:  rate_q <= cfg_data_i[RATE_W-1:0];
        CFG_REFERENCE_FREQ: ref_q  <= cfg_data_i[REF_W-1:0];
        CFG_LAG_COUNT:      lag_q  <= cfg_data_i[LAG_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  logic [NUM_CELLS:0] chain_v;
  spr_ctx_t           chain_ctx  [NUM_CELLS+1];
  spr_trig_t          chain_trig [NUM_CELLS+1];

  spr_front #(
    .MAX_LAGS  (MAX_LAGS),
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (in_valid_i),
    .sample_re_i   (sample_re_i),
    .sample_im_i   (sample_im_i),
    .bin_position_i(bin_position_i),
    .channel_freq_i(channel_freq_i),
    .period_index_i(period_index_i),
    .rate_i        (rate_q),
    .ref_freq_i    (ref_q),
    .lag_count_i   (lag_q),
    .valid_o       (chain_v[0]),
    .ctx_o         (chain_ctx[0]),
    .trig_o        (chain_trig[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    spr_cell #(
      .SIN_DIV(SIN_DIVS[k]),
      .COS_DIV(COS_DIVS[k])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(chain_v[k]),
      .ctx_i  (chain_ctx[k]),
      .trig_i (chain_trig[k]),
      .valid_o(chain_v[k+1]),
      .ctx_o  (chain_ctx[k+1]),
      .trig_o (chain_trig[k+1])
    );
  end

  spr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (chain_v[NUM_CELLS]),
    .ctx_i         (chain_ctx[NUM_CELLS]),
    .trig_i        (chain_trig[NUM_CELLS]),
    .valid_o       (out_valid_o),
    .out_re_o      (out_re_o),
    .out_im_o      (out_im_o),
    .out_position_o(out_position_o)
  );

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("word accepted while the output register is stalled");

  a_angle_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[0] |-> chain_trig[0].x <= X_MAX)
    else $error("folded angle lies outside the first octant");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_v[NUM_CELLS] |-> chain_trig[NUM_CELLS].tc <= ONE_Q &&
                           chain_trig[NUM_CELLS].tc != '0)
    else $error("cosine series left its range");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(chain_v) && $stable(chain_trig[NUM_CELLS]))
    else $error("pipeline moved while stalled");
`endif

endmodule

// File: hdl/spr_front.sv
module spr_front #(
  parameter int unsigned MAX_LAGS   = spr_pkg::MAX_LAGS_DEF,
  parameter int unsigned PHASE_BITS = spr_pkg::PHASE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [spr_pkg::SAMPLE_W-1:0] sample_im_i,
  input  logic [spr_pkg::POS_W-1:0]           bin_position_i,
  input  logic signed [spr_pkg::FREQ_W-1:0]   channel_freq_i,
  input  logic [spr_pkg::PERIOD_W-1:0]        period_index_i,
  input  logic signed [spr_pkg::RATE_W-1:0]   rate_i,
  input  logic signed [spr_pkg::REF_W-1:0]    ref_freq_i,
  input  logic [spr_pkg::LAG_W-1:0]           lag_count_i,
  output logic                                valid_o,
  output spr_pkg::spr_ctx_t                   ctx_o,
  output spr_pkg::spr_trig_t                  trig_o
);
  import spr_pkg::*;

  localparam int unsigned STAGES = 9;
  localparam int unsigned D_W    = 34;
  localparam int unsigned PROD_W = 56;
  localparam int unsigned HALF_W = PROD_W / 2;
  localparam int unsigned RF_W   = PHASE_BITS - 2;
  localparam int unsigned XM_W   = RF_W + 33;
  localparam logic [PROD_W-1:0] PH_RND = PROD_W'(1) << (PROD_W - 1 - PHASE_BITS);
  localparam logic [XM_W-1:0] X_RND = XM_W'(1) << (PHASE_BITS - 1);
  localparam logic [RF_W:0] QUARTER = (RF_W + 1)'(1) << RF_W;
  localparam logic [RF_W-1:0] HALF_QUARTER = RF_W'(1) << (RF_W - 1);
  localparam logic [2*X_W-1:0] SQ_RND = (2 * X_W)'(1) << (FRAC_Q - 1);

  logic [STAGES-1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  // Bin classification against the lag count.
  logic [LAG_W-1:0] lags;
  logic [LAG_W+1:0] lags3, lags4, pos_ext, top_diff;
  logic             lo_band, hi_band;
  spr_ctx_t         ctx1_d;

  always_comb begin
    lags     = (32'(lag_count_i) > 32'(MAX_LAGS)) ? LAG_W'(MAX_LAGS) : lag_count_i;
    lags4    = {lags, 2'b00};
    lags3    = {1'b0, lags, 1'b0} + {2'b00, lags};
    pos_ext  = {1'b0, bin_position_i};
    top_diff = lags4 - pos_ext;
    lo_band  = (bin_position_i != '0) && (pos_ext < {2'b00, lags});
    hi_band  = (pos_ext > lags3) && (pos_ext < lags4);
    ctx1_d   = '{re: sample_re_i, im: sample_im_i, pos: bin_position_i,
                 pass: !(lo_band || hi_band) || (rate_i == '0), quad: 2'b00, swap: 1'b0};
  end

  spr_ctx_t                   ctx1_q, ctx2_q, ctx3_q, ctx4_q, ctx5_q, ctx6_q, ctx7_q, ctx8_q;
  spr_ctx_t                   ctx9_q;
  logic signed [FREQ_W-1:0]   freq1_q;
  logic [PERIOD_W-1:0]        per1_q, per2_q, per3_q, per4_q;
  logic                       neg1_q;
  logic [LAG_W-1:0]           off1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx1_q  <= ctx1_d;
      freq1_q <= channel_freq_i;
      per1_q  <= period_index_i;
      neg1_q  <= !lo_band;
      off1_q  <= lo_band ? bin_position_i[LAG_W-1:0] : top_diff[LAG_W-1:0];
    end
  end

  logic signed [D_W-1:0] off_term, d_d;
  logic signed [D_W-1:0] d2_q;

  always_comb begin
    off_term = $signed({{(D_W - LAG_W - 8){1'b0}}, off1_q, 8'b0});
    d_d = D_W'(freq1_q) + (neg1_q ? -off_term : off_term) - D_W'(ref_freq_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q   <= d_d;
      per2_q <= per1_q;
      ctx2_q <= ctx1_q;
    end
  end

  logic [PROD_W-1:0] r56, d56, p_ll, p_hl, p_lh;
  logic [PROD_W-1:0] p_ll3_q;
  logic [HALF_W-1:0] p_hl3_q, p_lh3_q;

  always_comb begin
    r56  = PROD_W'(rate_i);
    d56  = PROD_W'(d2_q);
    p_ll = r56[HALF_W-1:0] * d56[HALF_W-1:0];
    p_hl = r56[PROD_W-1:HALF_W] * d56[HALF_W-1:0];
    p_lh = r56[HALF_W-1:0] * d56[PROD_W-1:HALF_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_ll3_q <= p_ll;
      p_hl3_q <= p_hl[HALF_W-1:0];
      p_lh3_q <= p_lh[HALF_W-1:0];
      per3_q  <= per2_q;
      ctx3_q  <= ctx2_q;
    end
  end

  logic [HALF_W-1:0] mid_sum;
  logic [PROD_W-1:0] a4_q;

  assign mid_sum = p_hl3_q + p_lh3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a4_q   <= p_ll3_q + {mid_sum, {HALF_W{1'b0}}};
      per4_q <= per3_q;
      ctx4_q <= ctx3_q;
    end
  end

  logic [HALF_W+PERIOD_W-1:0] q_l, q_h;
  logic [HALF_W+PERIOD_W-1:0] q_l5_q;
  logic [HALF_W-1:0]          q_h5_q;

  always_comb begin
    q_l = a4_q[HALF_W-1:0] * per4_q;
    q_h = a4_q[PROD_W-1:HALF_W] * per4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_l5_q <= q_l;
      q_h5_q <= q_h[HALF_W-1:0];
      ctx5_q <= ctx4_q;
    end
  end

  logic [PROD_W-1:0]     p_full;
  logic [PHASE_BITS-1:0] ph6_q;

  assign p_full = PROD_W'(q_l5_q) + {q_h5_q, {HALF_W{1'b0}}} + PH_RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph6_q  <= p_full[PROD_W-1 -: PHASE_BITS];
      ctx6_q <= ctx5_q;
    end
  end

  logic [RF_W-1:0] r_in;
  logic [RF_W:0]   r_mirror;
  logic            swap_d;
  spr_ctx_t        ctx7_d;
  logic [RF_W-1:0] rf7_q;

  always_comb begin
    r_in        = ph6_q[RF_W-1:0];
    r_mirror    = QUARTER - {1'b0, r_in};
    swap_d      = r_in > HALF_QUARTER;
    ctx7_d      = ctx6_q;
    ctx7_d.quad = ph6_q[PHASE_BITS-1 -: 2];
    ctx7_d.swap = swap_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rf7_q  <= swap_d ? r_mirror[RF_W-1:0] : r_in;
      ctx7_q <= ctx7_d;
    end
  end

  logic [XM_W-1:0] xm;
  logic [X_W-1:0]  x8_q;

  assign xm = rf7_q * TWO_PI_Q + X_RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x8_q   <= xm[PHASE_BITS +: X_W];
      ctx8_q <= ctx7_q;
    end
  end

  logic [2*X_W-1:0] sq;
  spr_trig_t        trig9_q;

  assign sq = x8_q * x8_q + SQ_RND;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig9_q <= '{x: x8_q, x2: sq[FRAC_Q +: X_W], ts: ONE_Q, tc: ONE_Q};
      ctx9_q  <= ctx8_q;
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign ctx_o   = ctx9_q;
  assign trig_o  = trig9_q;

endmodule

// File: hdl/spr_cell.sv
module spr_cell #(
  parameter int unsigned SIN_DIV = 6,
  parameter int unsigned COS_DIV = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  spr_pkg::spr_ctx_t  ctx_i,
  input  spr_pkg::spr_trig_t trig_i,
  output logic               valid_o,
  output spr_pkg::spr_ctx_t  ctx_o,
  output spr_pkg::spr_trig_t trig_o
);
  import spr_pkg::*;

  localparam int unsigned PA_W = X_W + T_W;
  localparam int unsigned PB_W = T_W + 32;
  localparam logic [PA_W-1:0] MUL_RND = PA_W'(1) << (FRAC_Q - 1);

  logic [2:0]     v_q;
  spr_ctx_t       ctx_a_q, ctx_b_q, ctx_c_q;
  logic [X_W-1:0] x_a_q, x_b_q, x_c_q, x2_a_q, x2_b_q, x2_c_q;
  logic [T_W-1:0] t_in [2];
  logic [T_W-1:0] t_out [2];

  assign t_in[0] = trig_i.ts;
  assign t_in[1] = trig_i.tc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_a_q <= ctx_i;
      ctx_b_q <= ctx_a_q;
      ctx_c_q <= ctx_b_q;
      x_a_q   <= trig_i.x;
      x_b_q   <= x_a_q;
      x_c_q   <= x_b_q;
      x2_a_q  <= trig_i.x2;
      x2_b_q  <= x2_a_q;
      x2_c_q  <= x2_b_q;
    end
  end

  // Lane 0 is the sine series, lane 1 the cosine series. A divisor of zero
  // marks the last sine step, which only multiplies by the angle.
  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int unsigned K = (l == 0) ? SIN_DIV : COS_DIV;
    localparam bit FINAL = (K == 0);
    localparam logic [32:0] RECIP = FINAL ? 33'd0 : 33'((64'd1 << 32) / (FINAL ? 1 : K));
    localparam logic [T_W-1:0] KC = T_W'(K);

    logic [X_W-1:0]  mcand;
    logic [PA_W-1:0] prod_a;
    logic [PB_W-1:0] prod_b;
    logic [T_W-1:0]  p_a_q, p_b_q, q_b_q, t_c_q;
    logic [T_W-1:0]  rem, q_fix, t_d;

    assign mcand  = FINAL ? trig_i.x : trig_i.x2;
    assign prod_a = mcand * t_in[l] + MUL_RND;
    assign prod_b = p_a_q * RECIP[31:0];

    always_comb begin
      rem   = p_b_q - q_b_q * KC;
      q_fix = q_b_q + {{(T_W - 1){1'b0}}, (rem >= KC)};
      if (FINAL) begin
        t_d = p_b_q;
      end else begin
        t_d = ONE_Q - q_fix;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_a_q <= prod_a[FRAC_Q +: T_W];
        p_b_q <= p_a_q;
        q_b_q <= prod_b[32 +: T_W];
        t_c_q <= t_d;
      end
    end

    assign t_out[l] = t_c_q;
  end

  assign valid_o = v_q[2];
  assign ctx_o   = ctx_c_q;
  assign trig_o  = '{x: x_c_q, x2: x2_c_q, ts: t_out[0], tc: t_out[1]};

endmodule

// File: hdl/spr_back.sv
module spr_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  spr_pkg::spr_ctx_t                   ctx_i,
  input  spr_pkg::spr_trig_t                  trig_i,
  output logic                                valid_o,
  output logic signed [spr_pkg::SAMPLE_W-1:0] out_re_o,
  output logic signed [spr_pkg::SAMPLE_W-1:0] out_im_o,
  output logic [spr_pkg::POS_W-1:0]           out_position_o
);
  import spr_pkg::*;

  localparam int unsigned CS_W  = T_W + 1;
  localparam int unsigned PR_W  = SAMPLE_W + CS_W;
  localparam int unsigned SUM_W = PR_W + 1;
  localparam int unsigned Q_W   = SUM_W - FRAC_Q;
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(1) << (FRAC_Q - 1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] q;
    q = v[SUM_W-1:FRAC_Q];
    if (q > SAT_HI) begin
      return SAMPLE_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      return SAMPLE_W'(SAT_LO);
    end
    return q[SAMPLE_W-1:0];
  endfunction

  logic [3:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  logic [T_W-1:0]         s_cl, c_cl, su, cu;
  logic signed [CS_W-1:0] s_sg, c_sg, cs_d, sn_d;
  logic signed [CS_W-1:0] cs1_q, sn1_q;
  spr_ctx_t               ctx1_q, ctx2_q, ctx3_q;

  always_comb begin
    s_cl = (trig_i.ts > ONE_Q) ? ONE_Q : trig_i.ts;
    c_cl = (trig_i.tc > ONE_Q) ? ONE_Q : trig_i.tc;
    su   = ctx_i.swap ? c_cl : s_cl;
    cu   = ctx_i.swap ? s_cl : c_cl;
    s_sg = $signed({1'b0, su});
    c_sg = $signed({1'b0, cu});
    case (ctx_i.quad)
      QUAD_FIRST: begin
        cs_d = c_sg;
        sn_d = s_sg;
      end
      QUAD_SECOND: begin
        cs_d = -s_sg;
        sn_d = c_sg;
      end
      QUAD_THIRD: begin
        cs_d = -c_sg;
        sn_d = -s_sg;
      end
      default: begin
        cs_d = s_sg;
        sn_d = -c_sg;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cs1_q  <= cs_d;
      sn1_q  <= sn_d;
      ctx1_q <= ctx_i;
    end
  end

  logic signed [PR_W-1:0] rc_d, is_d, rs_d, ic_d;
  logic signed [PR_W-1:0] rc2_q, is2_q, rs2_q, ic2_q;

  always_comb begin
    rc_d = $signed(ctx1_q.re) * cs1_q;
    is_d = $signed(ctx1_q.im) * sn1_q;
    rs_d = $signed(ctx1_q.re) * sn1_q;
    ic_d = $signed(ctx1_q.im) * cs1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rc2_q  <= rc_d;
      is2_q  <= is_d;
      rs2_q  <= rs_d;
      ic2_q  <= ic_d;
      ctx2_q <= ctx1_q;
    end
  end

  logic signed [SUM_W-1:0] vr3_q, vi3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vr3_q  <= SUM_W'(rc2_q) - SUM_W'(is2_q) + OUT_RND;
      vi3_q  <= SUM_W'(rs2_q) + SUM_W'(ic2_q) + OUT_RND;
      ctx3_q <= ctx2_q;
    end
  end

  logic signed [SAMPLE_W-1:0] re_q, im_q;
  logic [POS_W-1:0]           pos_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      re_q  <= ctx3_q.pass ? ctx3_q.re : sat_out(vr3_q);
      im_q  <= ctx3_q.pass ? ctx3_q.im : sat_out(vi3_q);
      pos_q <= ctx3_q.pos;
    end
  end

  assign valid_o        = v_q[3];
  assign out_re_o       = re_q;
  assign out_im_o       = im_q;
  assign out_position_o = pos_q;

endmodule
